// File: rtl/core/bcd_pkg.sv
package bcd_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PTR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W      = 7;
  localparam int unsigned OUT_DW     = 40;

  localparam logic [PTR_W-1:0] PTR_START = PTR_W'(DEPTH / 2);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  // back-end sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } st_e;

  // classified command between front and back
  typedef struct packed {
    logic                  pop;
    logic                  back_end;
    logic [DATA_WIDTH-1:0] data;
  } cmd_t;

  // ring pointer moves with wrap
  function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p);
    step_up = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
    step_down = (p == '0) ? PTR_LAST : p - PTR_W'(1);
  endfunction

endpackage

// File: rtl/core/bcd_front.sv
module bcd_front
  import bcd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_func_i,
  input  logic [DATA_WIDTH-1:0] in_data_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output cmd_t                  cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  // decode the operation into pop and end flags
  always_comb begin
    cmd_d.data = in_data_i;
    unique case (op_e'(in_func_i))
      OP_PUSH_FRONT: begin cmd_d.pop = 1'b0; cmd_d.back_end = 1'b0; end
      OP_PUSH_BACK:  begin cmd_d.pop = 1'b0; cmd_d.back_end = 1'b1; end
      OP_POP_FRONT:  begin cmd_d.pop = 1'b1; cmd_d.back_end = 1'b0; end
      OP_POP_BACK:   begin cmd_d.pop = 1'b1; cmd_d.back_end = 1'b1; end
      default:       begin cmd_d.pop = 1'b0; cmd_d.back_end = 1'b0; end
    endcase
  end

  // single holding stage
  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// File: rtl/core/bcd_cmd_queue.sv
module bcd_cmd_queue
  import bcd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_cmd_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign wr_ready_o = (fill_q != 2'd2);
  assign rd_valid_o = (fill_q != 2'd0);
  assign rd_cmd_o   = entry_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

// File: rtl/core/bcd_back.sv
module bcd_back
  import bcd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  cmd_t                  cmd_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic                  res_ok_o,
  output logic [DATA_WIDTH-1:0] res_data_o,
  output logic [OCC_W-1:0]      res_occ_o
);

  logic [DATA_WIDTH-1:0] ring_mem [DEPTH];

  st_e              state_q, state_d;
  logic [PTR_W-1:0] front_q, front_d;
  logic [PTR_W-1:0] back_q, back_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ok_q, ok_d;
  logic             pop_q;
  logic [DATA_WIDTH-1:0] rd_data_q;

  logic             take;
  logic             is_full, is_empty;
  logic [PTR_W-1:0] cur_ptr, new_ptr;
  logic             wr_en, rd_en;

  assign take     = cmd_valid_i && cmd_ready_o;
  assign is_full  = (count_q == CNT_FULL);
  assign is_empty = (count_q == '0);
  assign cur_ptr  = cmd_i.back_end ? back_q : front_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_valid_i) state_d = ST_RESP;
      ST_RESP: if (res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: cmd_ready_o = 1'b1;
      ST_RESP: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // execute one command: pointers, count and store access
  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    count_d = count_q;
    ok_d    = 1'b0;
    new_ptr = cur_ptr;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    if (!cmd_i.pop) begin
      // push moves outward unless the deque is empty
      if (!is_empty) begin
        new_ptr = cmd_i.back_end ? step_up(cur_ptr) : step_down(cur_ptr);
      end
      if (take && !is_full) begin
        ok_d    = 1'b1;
        wr_en   = 1'b1;
        count_d = count_q + CNT_W'(1);
        if (cmd_i.back_end) back_d = new_ptr;
        else                front_d = new_ptr;
      end
    end else begin
      // pop moves inward unless it removes the last element
      if (count_q > CNT_W'(1)) begin
        new_ptr = cmd_i.back_end ? step_down(cur_ptr) : step_up(cur_ptr);
      end
      if (take && !is_empty) begin
        ok_d    = 1'b1;
        rd_en   = 1'b1;
        count_d = count_q - CNT_W'(1);
        if (cmd_i.back_end) back_d = new_ptr;
        else                front_d = new_ptr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      front_q <= PTR_START;
      back_q  <= PTR_START;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  // result flags held for the output word
  always_ff @(posedge clk_i) begin
    if (take) begin
      ok_q  <= ok_d;
      pop_q <= cmd_i.pop;
    end
  end

  // ring store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[new_ptr] <= cmd_i.data;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[cur_ptr];
    end
  end

  assign res_ok_o   = ok_q;
  assign res_data_o = (ok_q && pop_q) ? rd_data_q : '0;
  assign res_occ_o  = OCC_W'(count_q);

endmodule

// File: rtl/core/bounded_circular_deque_unit.sv
// an accepted input word passes the front holding register, the command queue
// and the back-end sequencer, which executes a command and then holds the result
// until taken, taking no new command while a result waits
// reset: asynchronous, active low; deque empty, both pointers at mid-ring,
// store contents undefined until written
module bounded_circular_deque_unit
  import bcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // [31:0] data_in
  input  logic [1:0]        s_axis_tuser,  // [1:0] func
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,  // [31:0] data_out, [38:32] occupancy, [39] zero
  output logic [0:0]        m_axis_tuser   // [0] ok
);

  logic                  f_valid, f_ready;
  cmd_t                  f_cmd;
  logic                  q_valid, q_ready;
  cmd_t                  q_cmd;
  logic                  res_ok;
  logic [DATA_WIDTH-1:0] res_data;
  logic [OCC_W-1:0]      res_occ;

  // front: accept and classify
  bcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata[DATA_WIDTH-1:0]),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  // decoupling queue
  bcd_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_cmd_i   (f_cmd),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_cmd_o   (q_cmd)
  );

  // back: execute against the ring store
  bcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_ok_o    (res_ok),
    .res_data_o  (res_data),
    .res_occ_o   (res_occ)
  );

  // pack the output word
  assign m_axis_tdata = {1'b0, res_occ, res_data};
  assign m_axis_tuser = res_ok;

endmodule

// File: test/deque_checker.sv
`timescale 1ns / 100ps

module deque_checker
  import bcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [31:0]       s_tdata_i,  // [31:0] data_in
  input  logic [1:0]        s_tuser_i,  // [1:0] func
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [OUT_DW-1:0] m_tdata_i,  // [31:0] data_out, [38:32] occupancy, [39] zero
  input  logic [0:0]        m_tuser_i,  // [0] ok
  output int                errors_o,
  output int                pending_o
);

  // one expected result word
  typedef struct {
    logic                  ok;
    logic [DATA_WIDTH-1:0] data;
    logic [OCC_W-1:0]      occ;
  } deque_result_t;

  deque_result_t         expected_q[$];
  logic [DATA_WIDTH-1:0] ring [DEPTH];
  int unsigned           front_idx;
  int unsigned           back_idx;
  int unsigned           fill_level;
  int                    errors;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  // deque behaviour for one operation, updates the shadow state
  function automatic deque_result_t apply_op(op_e op, logic [DATA_WIDTH-1:0] value);
    deque_result_t res;
    res.ok   = 1'b0;
    res.data = '0;
    case (op) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_level < DEPTH) begin
          // an empty deque takes the first element in place
          if (fill_level > 0) begin
            if (op == OP_PUSH_FRONT) front_idx = (front_idx + DEPTH - 1) % DEPTH;
            else back_idx = (back_idx + 1) % DEPTH;
          end
          ring[PTR_W'((op == OP_PUSH_FRONT) ? front_idx : back_idx)] = value;
          fill_level++;
          res.ok = 1'b1;
        end
      end
      default: begin
        if (fill_level > 0) begin
          res.data = ring[PTR_W'((op == OP_POP_FRONT) ? front_idx : back_idx)];
          // removing the last element leaves both pointers put
          if (fill_level > 1) begin
            if (op == OP_POP_FRONT) front_idx = (front_idx + 1) % DEPTH;
            else back_idx = (back_idx + DEPTH - 1) % DEPTH;
          end
          fill_level--;
          res.ok = 1'b1;
        end
      end
    endcase
    res.occ = OCC_W'(fill_level);
    return res;
  endfunction

  // log a mismatch, only the first few in full
  function automatic void flag_error(string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  // predict on accepted input words, compare on accepted output words
  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t            want;
    logic [DATA_WIDTH-1:0]    got_data;
    logic [OCC_W-1:0]         got_occ;
    logic [OUT_DW-1:DATA_WIDTH+OCC_W] got_pad;
    if (!rst_ni) begin
      expected_q.delete();
      front_idx  = DEPTH / 2;
      back_idx   = DEPTH / 2;
      fill_level = 0;
      errors     = 0;
    end else begin
      if (s_tvalid_i && s_tready_i)
        expected_q.push_back(apply_op(op_e'(s_tuser_i), s_tdata_i[DATA_WIDTH-1:0]));
      if (m_tvalid_i && m_tready_i) begin
        got_data = m_tdata_i[DATA_WIDTH-1:0];
        got_occ  = m_tdata_i[DATA_WIDTH +: OCC_W];
        got_pad  = m_tdata_i[OUT_DW-1:DATA_WIDTH+OCC_W];
        if (expected_q.size() == 0) begin
          flag_error($sformatf("unexpected word ok=%0d data=%08h occ=%0d",
                               m_tuser_i[0], got_data, got_occ));
        end else begin
          want = expected_q.pop_front();
          if (m_tuser_i[0] !== want.ok)
            flag_error($sformatf("ok: expected %0d, got %0d", want.ok, m_tuser_i[0]));
          if (got_data !== want.data)
            flag_error($sformatf("data_out: expected %08h, got %08h", want.data, got_data));
          if (got_occ !== want.occ)
            flag_error($sformatf("occupancy: expected %0d, got %0d", want.occ, got_occ));
          if (got_pad !== '0)
            flag_error($sformatf("pad bits: expected 0, got %0h", got_pad));
        end
      end
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bcd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 330;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;  // [31:0] data_in
  logic [1:0]        s_axis_tuser = '0;  // [1:0] func
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;  // [31:0] data_out, [38:32] occupancy, [39] zero
  logic [0:0]        m_axis_tuser;  // [0] ok

  int errors;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  bounded_circular_deque_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  deque_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side back-pressure, with a long hold-off on request
  initial begin
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  // stop if no word moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else if (rst_ni) quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // offer one word, with random idle cycles ahead of it
  task automatic send_word(op_e op, logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // element values, edge patterns now and then
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  // runs biased towards filling, draining or churning the deque
  task automatic churn_deque(int items);
    int left;
    int run_len;
    int push_pct;
    op_e op;
    left = items;
    while (left > 0) begin
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      run_len = $urandom_range(20, 120);
      if (run_len > left) run_len = left;
      repeat (run_len) begin
        if ($urandom_range(99) < push_pct)
          op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else
          op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
        send_word(op, pick_value());
      end
      left -= run_len;
    end
  endtask

  // reset, directed cases, then three phases of random traffic, the last without idling
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 67;

    // pops on an empty deque are refused
    send_word(OP_POP_FRONT, 32'hdead_beef);
    send_word(OP_POP_BACK, 32'hffff_ffff);
    // push into empty, then pop of the last element from the other end
    send_word(OP_PUSH_FRONT, 32'h0000_0000);
    send_word(OP_POP_BACK, 32'h0000_0000);
    send_word(OP_PUSH_BACK, 32'hffff_ffff);
    send_word(OP_POP_FRONT, 32'h0000_0000);
    // build from both ends, drain from both ends
    send_word(OP_PUSH_FRONT, 32'ha5a5_a5a5);
    send_word(OP_PUSH_FRONT, 32'h5a5a_5a5a);
    send_word(OP_PUSH_BACK, 32'h0000_0001);
    send_word(OP_PUSH_BACK, 32'h8000_0000);
    send_word(OP_POP_FRONT, 32'h0000_0000);
    send_word(OP_POP_BACK, 32'h0000_0000);
    send_word(OP_POP_BACK, 32'h0000_0000);
    send_word(OP_POP_FRONT, 32'h0000_0000);
    send_word(OP_POP_FRONT, 32'h0000_0000);
    // pointers stay mid-ring after the drain
    send_word(OP_PUSH_BACK, 32'h1234_5678);
    send_word(OP_PUSH_FRONT, 32'h8765_4321);
    send_word(OP_POP_BACK, 32'h0000_0000);
    send_word(OP_POP_BACK, 32'h0000_0000);
    send_word(OP_POP_BACK, 32'h0000_0000);

    churn_deque(PHASE_ITEMS);

    send_idle_pct = 67;
    recv_idle_pct = 27;
    churn_deque(PHASE_ITEMS);

    // no idling; the result side first stalls while words keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    churn_deque(PHASE_ITEMS + 10);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bcd_pkg.sv
rtl/core/bcd_front.sv
rtl/core/bcd_cmd_queue.sv
rtl/core/bcd_back.sv
rtl/core/bounded_circular_deque_unit.sv
test/deque_checker.sv
test/testbench.sv
